### src/priority_round_robin_task_scheduler_macros.svh
// Assertion helpers for the task scheduler
`ifndef PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define PRIORITY_ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

`define PRRTS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("scheduler invariant failed");

`define PRRTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler sequence check failed");

`endif

### src/prrts_pkg.sv
package prrts_pkg;

    localparam int MAX_SLOTS_DEF   = 16;
    localparam int PRIO_LEVELS_DEF = 4;
    localparam int PRIO_W          = 3;

    localparam logic [2:0] ST_READY    = 3'd0;
    localparam logic [2:0] ST_RUNNING  = 3'd1;
    localparam logic [2:0] ST_SLEEPING = 3'd2;
    localparam logic [2:0] ST_BLOCKED  = 3'd3;
    localparam logic [2:0] ST_DEAD     = 3'd4;

    localparam logic [2:0] CMD_CREATE = 3'd0;
    localparam logic [2:0] CMD_YIELD  = 3'd1;
    localparam logic [2:0] CMD_SLEEP  = 3'd2;
    localparam logic [2:0] CMD_EXIT   = 3'd3;
    localparam logic [2:0] CMD_WAIT   = 3'd4;

    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_FULL      = 2'd1;
    localparam logic [1:0] STS_NOT_FOUND = 2'd2;

    localparam logic [1:0] AS_I   = 2'd0;
    localparam logic [1:0] AS_J   = 2'd1;
    localparam logic [1:0] AS_CUR = 2'd2;
    localparam logic [1:0] AS_TGT = 2'd3;

    localparam logic [4:0] OP_NOP       = 5'd0;
    localparam logic [4:0] OP_LOAD      = 5'd1;
    localparam logic [4:0] OP_CR_STEP   = 5'd2;
    localparam logic [4:0] OP_CR_APPEND = 5'd3;
    localparam logic [4:0] OP_CR_WRITE  = 5'd4;
    localparam logic [4:0] OP_WT_MISS   = 5'd5;
    localparam logic [4:0] OP_WT_STEP   = 5'd6;
    localparam logic [4:0] OP_MOD       = 5'd7;
    localparam logic [4:0] OP_P1_STEP   = 5'd8;
    localparam logic [4:0] OP_P2_INIT   = 5'd9;
    localparam logic [4:0] OP_P2_NEXTJ  = 5'd10;
    localparam logic [4:0] OP_P2_STEP   = 5'd11;
    localparam logic [4:0] OP_P3_INIT   = 5'd12;
    localparam logic [4:0] OP_P3_STEP   = 5'd13;
    localparam logic [4:0] OP_P4_INIT   = 5'd14;
    localparam logic [4:0] OP_P4_STEP   = 5'd15;
    localparam logic [4:0] OP_SW_OLD    = 5'd16;
    localparam logic [4:0] OP_SW_NEW    = 5'd17;
    localparam logic [4:0] OP_FIN       = 5'd18;
    localparam logic [4:0] OP_EMIT      = 5'd19;
    localparam logic [4:0] OP_I_CLR     = 5'd20;

    typedef struct packed {
        logic [2:0]        state;
        logic [PRIO_W-1:0] prio;
        logic              held;
        logic [15:0]       id;
        logic [31:0]       wake;
        logic [15:0]       wait_for;
        logic [15:0]       code;
    } t_slot;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] asel;
    } t_cmd;

    typedef struct packed {
        logic [2:0] cmd;
        logic       end_lt;
        logic       end_le;
        logic       j_end;
        logic       reuse;
        logic       match;
        logic       dead;
        logic       same;
        logic       can_append;
        logic       out_free;
    } t_sts;

endpackage

### src/prrts_if.sv
interface prrts_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [1:0]  priority_req;
    logic [31:0] now_tick;
    logic [31:0] sleep_ticks;
    logic [15:0] target_id;
    logic signed [15:0] exit_value;

    modport source (output valid, output cmd, output priority_req, output now_tick,
                    output sleep_ticks, output target_id, output exit_value, input ready);
    modport sink (input valid, input cmd, input priority_req, input now_tick,
                  input sleep_ticks, input target_id, input exit_value, output ready);
endinterface

interface prrts_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  running_slot;
    logic        switched;
    logic [15:0] created_id;
    logic signed [15:0] result_code;

    modport source (output valid, output status, output running_slot, output switched,
                    output created_id, output result_code, input ready);
    modport sink (input valid, input status, input running_slot, input switched,
                  input created_id, input result_code, output ready);
endinterface

### src/prrts_ctrl.sv
module prrts_ctrl
    import prrts_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DISP   = 5'd1;
    localparam logic [4:0] S_CR_RD  = 5'd2;
    localparam logic [4:0] S_CR_EX  = 5'd3;
    localparam logic [4:0] S_CR_SEL = 5'd4;
    localparam logic [4:0] S_CR_WRD = 5'd5;
    localparam logic [4:0] S_CR_WEX = 5'd6;
    localparam logic [4:0] S_WT_RD  = 5'd7;
    localparam logic [4:0] S_WT_EX  = 5'd8;
    localparam logic [4:0] S_MOD_RD = 5'd9;
    localparam logic [4:0] S_MOD_EX = 5'd10;
    localparam logic [4:0] S_P1_RD  = 5'd11;
    localparam logic [4:0] S_P1_EX  = 5'd12;
    localparam logic [4:0] S_P2_RD  = 5'd13;
    localparam logic [4:0] S_P2_EX  = 5'd14;
    localparam logic [4:0] S_P3_RD  = 5'd15;
    localparam logic [4:0] S_P3_EX  = 5'd16;
    localparam logic [4:0] S_P4_RD  = 5'd17;
    localparam logic [4:0] S_P4_EX  = 5'd18;
    localparam logic [4:0] S_SW_RD  = 5'd19;
    localparam logic [4:0] S_SW_EX  = 5'd20;
    localparam logic [4:0] S_SW2_RD = 5'd21;
    localparam logic [4:0] S_SW2_EX = 5'd22;
    localparam logic [4:0] S_FIN_RD = 5'd23;
    localparam logic [4:0] S_FIN_EX = 5'd24;
    localparam logic [4:0] S_EMIT   = 5'd25;

    logic [4:0] r_state;
    logic [4:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NOP;
        o_cmd.asel = AS_I;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                unique case (i_sts.cmd)
                    CMD_CREATE: n_state = S_CR_RD;
                    CMD_YIELD: begin
                        o_cmd.op = OP_I_CLR;
                        n_state  = S_P1_RD;
                    end
                    CMD_SLEEP, CMD_EXIT: n_state = S_MOD_RD;
                    CMD_WAIT: n_state = S_WT_RD;
                    default: n_state = S_FIN_RD;
                endcase
            end
            S_CR_RD: begin
                n_state = i_sts.end_lt ? S_CR_SEL : S_CR_EX;
            end
            S_CR_EX: begin
                o_cmd.op = OP_CR_STEP;
                n_state  = i_sts.reuse ? S_CR_WRD : S_CR_RD;
            end
            S_CR_SEL: begin
                o_cmd.op = OP_CR_APPEND;
                n_state  = i_sts.can_append ? S_CR_WRD : S_FIN_RD;
            end
            S_CR_WRD: begin
                o_cmd.asel = AS_TGT;
                n_state    = S_CR_WEX;
            end
            S_CR_WEX: begin
                o_cmd.asel = AS_TGT;
                o_cmd.op   = OP_CR_WRITE;
                n_state    = S_FIN_RD;
            end
            S_WT_RD: begin
                if (i_sts.end_lt) begin
                    o_cmd.op = OP_WT_MISS;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_WT_EX;
                end
            end
            S_WT_EX: begin
                o_cmd.op = OP_WT_STEP;
                priority if (i_sts.match && i_sts.dead) n_state = S_EMIT;
                else if (i_sts.match) n_state = S_MOD_RD;
                else n_state = S_WT_RD;
            end
            S_MOD_RD: begin
                o_cmd.asel = AS_CUR;
                n_state    = S_MOD_EX;
            end
            S_MOD_EX: begin
                o_cmd.asel = AS_CUR;
                o_cmd.op   = OP_MOD;
                n_state    = S_P1_RD;
            end
            S_P1_RD: begin
                if (i_sts.end_lt) begin
                    o_cmd.op = OP_P2_INIT;
                    n_state  = S_P2_RD;
                end else begin
                    n_state = S_P1_EX;
                end
            end
            S_P1_EX: begin
                o_cmd.op = OP_P1_STEP;
                n_state  = S_P1_RD;
            end
            S_P2_RD: begin
                o_cmd.asel = AS_J;
                priority if (i_sts.j_end) begin
                    o_cmd.op = OP_P3_INIT;
                    n_state  = S_P3_RD;
                end else if (i_sts.end_lt) begin
                    o_cmd.op = OP_P2_NEXTJ;
                end else begin
                    n_state = S_P2_EX;
                end
            end
            S_P2_EX: begin
                o_cmd.asel = AS_J;
                o_cmd.op   = OP_P2_STEP;
                n_state    = S_P2_RD;
            end
            S_P3_RD: begin
                if (i_sts.end_lt) begin
                    o_cmd.op = OP_P4_INIT;
                    n_state  = S_P4_RD;
                end else begin
                    n_state = S_P3_EX;
                end
            end
            S_P3_EX: begin
                o_cmd.op = OP_P3_STEP;
                n_state  = S_P3_RD;
            end
            S_P4_RD: begin
                o_cmd.asel = AS_J;
                n_state    = i_sts.end_le ? S_SW_RD : S_P4_EX;
            end
            S_P4_EX: begin
                o_cmd.asel = AS_J;
                o_cmd.op   = OP_P4_STEP;
                n_state    = S_P4_RD;
            end
            S_SW_RD: begin
                o_cmd.asel = AS_CUR;
                n_state    = i_sts.same ? S_FIN_RD : S_SW_EX;
            end
            S_SW_EX: begin
                o_cmd.asel = AS_CUR;
                o_cmd.op   = OP_SW_OLD;
                n_state    = S_SW2_RD;
            end
            S_SW2_RD: begin
                o_cmd.asel = AS_TGT;
                n_state    = S_SW2_EX;
            end
            S_SW2_EX: begin
                o_cmd.asel = AS_TGT;
                o_cmd.op   = OP_SW_NEW;
                n_state    = S_FIN_RD;
            end
            S_FIN_RD: begin
                o_cmd.asel = AS_CUR;
                n_state    = S_FIN_EX;
            end
            S_FIN_EX: begin
                o_cmd.asel = AS_CUR;
                o_cmd.op   = OP_FIN;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### src/prrts_dpath.sv
`include "priority_round_robin_task_scheduler_macros.svh"

module prrts_dpath
    import prrts_pkg::*;
#(
    parameter int MAX_SLOTS       = MAX_SLOTS_DEF,
    parameter int PRIORITY_LEVELS = PRIO_LEVELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic [2:0]         i_cmd_code,
    input  logic [1:0]         i_priority_req,
    input  logic [31:0]        i_now_tick,
    input  logic [31:0]        i_sleep_ticks,
    input  logic [15:0]        i_target_id,
    input  logic signed [15:0] i_exit_value,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [1:0]         o_status,
    output logic [3:0]         o_running_slot,
    output logic               o_switched,
    output logic [15:0]        o_created_id,
    output logic signed [15:0] o_result_code
);

    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW = $clog2(MAX_SLOTS + 2);

    t_slot                 mem [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]  r_vld;
    t_slot                 r_qa;
    t_slot                 r_qb;

    logic [CW-1:0]     r_i;
    logic [CW-1:0]     r_j;
    logic [CW-1:0]     r_used;
    logic [IW-1:0]     r_cur;
    logic [IW-1:0]     r_tgt;
    logic [15:0]       r_idc;
    logic [PRIO_W-1:0] r_best;
    logic              r_found;

    logic [2:0]  r_cmd;
    logic [1:0]  r_prio;
    logic [31:0] r_now;
    logic [31:0] r_ticks;
    logic [15:0] r_target;
    logic [15:0] r_code;

    logic [1:0]  r_status;
    logic        r_sw;
    logic [15:0] r_created;
    logic [15:0] r_res;
    logic        r_res_set;

    logic        r_ov;
    logic [1:0]  r_o_status;
    logic [3:0]  r_o_slot;
    logic        r_o_sw;
    logic [15:0] r_o_created;
    logic [15:0] r_o_res;

    logic [IW-1:0]     ra;
    logic [IW-1:0]     rb;
    logic              wen;
    logic [IW-1:0]     wa;
    t_slot             wd;
    logic [32:0]       wake_sum;
    logic [31:0]       wake_sat;
    logic [PRIO_W-1:0] prio_c;
    logic              p2_hit;
    logic [CW-1:0]     j_first;
    logic [CW-1:0]     j_inc;
    logic              out_free;

    function automatic t_slot rst_rec(input logic [IW-1:0] a);
        t_slot r;
        r = '0;
        if (a == '0) begin
            r.state = ST_RUNNING;
            r.prio  = PRIO_W'(PRIORITY_LEVELS - 1);
        end else begin
            r.state = ST_READY;
        end
        return r;
    endfunction

    always_comb begin
        unique case (i_cmd.asel)
            AS_I:   ra = r_i[IW-1:0];
            AS_J:   ra = r_j[IW-1:0];
            AS_CUR: ra = r_cur;
            AS_TGT: ra = r_tgt;
            default: ra = r_cur;
        endcase
    end
    assign rb = r_i[IW-1:0];

    assign wake_sum = {1'b0, r_now} + {1'b0, r_ticks};
    assign wake_sat = wake_sum[32] ? 32'hFFFF_FFFF : wake_sum[31:0];
    assign prio_c   = (int'(r_prio) >= PRIORITY_LEVELS) ? PRIO_W'(PRIORITY_LEVELS - 1)
                                                        : PRIO_W'(r_prio);
    assign p2_hit   = (r_qa.state == ST_BLOCKED) && (r_qb.state == ST_DEAD)
                    && (r_i[IW-1:0] != r_cur) && (r_qa.wait_for == r_qb.id);
    assign j_first  = ((CW'(r_cur) + 1'b1) == r_used) ? '0 : CW'(r_cur) + 1'b1;
    assign j_inc    = ((r_j + 1'b1) == r_used) ? '0 : r_j + 1'b1;
    assign out_free = !r_ov || i_out_ready;

    always_comb begin
        wen = 1'b0;
        wa  = r_cur;
        wd  = r_qa;
        unique case (i_cmd.op)
            OP_CR_WRITE: begin
                wen         = 1'b1;
                wa          = r_tgt;
                wd.id       = r_idc;
                wd.state    = ST_READY;
                wd.prio     = prio_c;
                wd.code     = '0;
                wd.wait_for = '0;
                wd.held     = 1'b1;
            end
            OP_MOD: begin
                wen = 1'b1;
                wa  = r_cur;
                unique case (r_cmd)
                    CMD_SLEEP: begin
                        wd.state = ST_SLEEPING;
                        wd.wake  = wake_sat;
                    end
                    CMD_EXIT: begin
                        wd.state = ST_DEAD;
                        wd.code  = r_code;
                    end
                    default: begin
                        wd.state    = ST_BLOCKED;
                        wd.wait_for = r_target;
                    end
                endcase
            end
            OP_P1_STEP: begin
                wen      = (r_qa.state == ST_SLEEPING) && (r_now >= r_qa.wake);
                wa       = r_i[IW-1:0];
                wd.state = ST_READY;
            end
            OP_P2_STEP: begin
                wen         = p2_hit;
                wa          = r_j[IW-1:0];
                wd.state    = ST_READY;
                wd.code     = r_qb.code;
                wd.wait_for = '0;
            end
            OP_P3_STEP: begin
                wen     = (r_qa.state == ST_DEAD) && (r_i[IW-1:0] != r_cur);
                wa      = r_i[IW-1:0];
                wd.held = 1'b0;
            end
            OP_SW_OLD: begin
                wen      = (r_qa.state == ST_RUNNING);
                wa       = r_cur;
                wd.state = ST_READY;
            end
            OP_SW_NEW: begin
                wen      = 1'b1;
                wa       = r_tgt;
                wd.state = ST_RUNNING;
            end
            default: wen = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wen) begin
            mem[wa] <= wd;
        end
        r_qa <= r_vld[ra] ? mem[ra] : rst_rec(ra);
        r_qb <= r_vld[rb] ? mem[rb] : rst_rec(rb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wen) begin
            r_vld[wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.op == OP_EMIT) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= CW'(1);
            r_cur   <= '0;
            r_idc   <= 16'd1;
            r_i     <= '0;
            r_j     <= '0;
            r_found <= 1'b0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_cmd     <= i_cmd_code;
                    r_prio    <= i_priority_req;
                    r_now     <= i_now_tick;
                    r_ticks   <= i_sleep_ticks;
                    r_target  <= i_target_id;
                    r_code    <= i_exit_value;
                    r_status  <= STS_OK;
                    r_sw      <= 1'b0;
                    r_created <= '0;
                    r_res_set <= 1'b0;
                    r_i       <= (i_cmd_code == CMD_CREATE) ? CW'(1) : '0;
                end
                OP_I_CLR: r_i <= '0;
                OP_CR_STEP: begin
                    if (o_sts.reuse) begin
                        r_tgt <= r_i[IW-1:0];
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                OP_CR_APPEND: begin
                    if (o_sts.can_append) begin
                        r_tgt <= r_used[IW-1:0];
                    end else begin
                        r_status <= STS_FULL;
                    end
                end
                OP_CR_WRITE: begin
                    if (CW'(r_tgt) >= r_used) begin
                        r_used <= CW'(r_tgt) + 1'b1;
                    end
                    r_created <= r_idc;
                    r_idc     <= r_idc + 16'd1;
                end
                OP_WT_MISS: begin
                    r_status  <= STS_NOT_FOUND;
                    r_res     <= 16'hFFFF;
                    r_res_set <= 1'b1;
                end
                OP_WT_STEP: begin
                    if (o_sts.match) begin
                        if (o_sts.dead) begin
                            r_res     <= r_qa.code;
                            r_res_set <= 1'b1;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                OP_MOD: r_i <= '0;
                OP_P1_STEP, OP_P2_STEP, OP_P3_STEP: r_i <= r_i + 1'b1;
                OP_P2_INIT: begin
                    r_j <= '0;
                    r_i <= CW'(1);
                end
                OP_P2_NEXTJ: begin
                    r_j <= r_j + 1'b1;
                    r_i <= CW'(1);
                end
                OP_P3_INIT: r_i <= CW'(1);
                OP_P4_INIT: begin
                    r_i     <= CW'(1);
                    r_j     <= j_first;
                    r_found <= 1'b0;
                    r_tgt   <= '0;
                end
                OP_P4_STEP: begin
                    if ((r_qa.state == ST_READY) && (!r_found || (r_qa.prio < r_best))) begin
                        r_tgt   <= r_j[IW-1:0];
                        r_best  <= r_qa.prio;
                        r_found <= 1'b1;
                    end
                    r_i <= r_i + 1'b1;
                    r_j <= j_inc;
                end
                OP_SW_NEW: begin
                    r_cur <= r_tgt;
                    r_sw  <= 1'b1;
                end
                OP_FIN: begin
                    if (!r_res_set) begin
                        r_res <= r_qa.code;
                    end
                end
                OP_EMIT: begin
                    r_o_status  <= r_status;
                    r_o_slot    <= 4'(r_cur);
                    r_o_sw      <= r_sw;
                    r_o_created <= r_created;
                    r_o_res     <= r_res;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.end_lt     = (r_i >= r_used);
        o_sts.end_le     = (r_i > r_used);
        o_sts.j_end      = (r_j >= r_used);
        o_sts.reuse      = (r_qa.state == ST_DEAD) && !r_qa.held;
        o_sts.match      = (r_qa.id == r_target);
        o_sts.dead       = (r_qa.state == ST_DEAD);
        o_sts.same       = (r_tgt == r_cur);
        o_sts.can_append = (r_used < CW'(MAX_SLOTS));
        o_sts.out_free   = out_free;
    end

    assign o_out_valid    = r_ov;
    assign o_status       = r_o_status;
    assign o_running_slot = r_o_slot;
    assign o_switched     = r_o_sw;
    assign o_created_id   = r_o_created;
    assign o_result_code  = r_o_res;

    `PRRTS_ASSERT_ALWAYS(a_cur_in_table, i_clk, i_rst_n, CW'(r_cur) < r_used)
    `PRRTS_ASSERT_ALWAYS(a_used_range, i_clk, i_rst_n, (r_used != '0) && (r_used <= CW'(MAX_SLOTS)))
    `PRRTS_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, i_cmd.op == OP_EMIT, r_ov)

endmodule

### src/priority_round_robin_task_scheduler.sv
// Channel   Dir  Modport  Payload
// i_req     in   sink     cmd, priority_req, now_tick, sleep_ticks, target_id, exit_value
// o_rsp     out  source   status, running_slot, switched, created_id, result_code
//
// One request at a time; each table step addresses a slot, then uses the read data.
// The pass time is set by the nested dead-slot/waiter scan on the table.
// Reset is synchronous; per-slot valid bits give the reset table at once, no clearing sweep.
// A finished response waits in the output register; the next request is taken meanwhile.
module priority_round_robin_task_scheduler
    import prrts_pkg::*;
#(
    parameter int MAX_SLOTS       = MAX_SLOTS_DEF,
    parameter int PRIORITY_LEVELS = PRIO_LEVELS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    prrts_in_if.sink    i_req,
    prrts_out_if.source o_rsp
);

    t_cmd cmd;
    t_sts sts;

    prrts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    prrts_dpath #(
        .MAX_SLOTS       (MAX_SLOTS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_cmd_code     (i_req.cmd),
        .i_priority_req (i_req.priority_req),
        .i_now_tick     (i_req.now_tick),
        .i_sleep_ticks  (i_req.sleep_ticks),
        .i_target_id    (i_req.target_id),
        .i_exit_value   (i_req.exit_value),
        .i_out_ready    (o_rsp.ready),
        .o_out_valid    (o_rsp.valid),
        .o_status       (o_rsp.status),
        .o_running_slot (o_rsp.running_slot),
        .o_switched     (o_rsp.switched),
        .o_created_id   (o_rsp.created_id),
        .o_result_code  (o_rsp.result_code)
    );

endmodule
